// File: hdl/apfb_pkg.sv
// shared types and constants for the augmenting path flow block
package apfb_pkg;

  localparam int NODE_W         = 6;
  localparam int CAP_W          = 31;
  localparam int FLOW_W         = 32;
  localparam int DEF_MAX_NODES  = 64;
  localparam int DEF_MAX_DEGREE = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 6;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_ZERO   = 2'd2;
  localparam logic [1:0] OP_RUN    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd3;

  // run modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_AVOID = 2'd1;
  localparam logic [1:0] MODE_BETW  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [CAP_W-1:0]  edge_capacity;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FLOW_W-1:0] total_flow;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic clr_graph;
    logic deg_rd_from;
    logic append_wr;
    logic sweep_wr;
    logic phase_init;
    logic srch_init;
    logic q_rd;
    logic cur_load;
    logic deg_cap;
    logic edge_rd;
    logic edge_eval;
    logic neck_init;
    logic walk_init;
    logic pred_rd;
    logic walk_edge_rd;
    logic neck_upd;
    logic flow_upd;
    logic total_add;
    logic pass_next;
    logic emit_run;
    logic emit_ok;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       run_bad;
    logic       sweep_last;
    logic       q_empty;
    logic       k_done;
    logic       sink_reached;
    logic       walk_more;
    logic       two_pass;
    logic       first_pass;
  } sts_t;

endpackage

// File: hdl/apfb_ctrl.sv
// sequencer for graph load, flow sweep, search and path walks
module apfb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  apfb_pkg::sts_t sts,
  output apfb_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_DISP  = 19'h00002,
    S_APP   = 19'h00004,
    S_SWEEP = 19'h00008,
    S_SINIT = 19'h00010,
    S_POP   = 19'h00020,
    S_NODE  = 19'h00040,
    S_DEG   = 19'h00080,
    S_EDGE  = 19'h00100,
    S_EVAL  = 19'h00200,
    S_WCHK  = 19'h00400,
    S_W1P   = 19'h00800,
    S_W1E   = 19'h01000,
    S_W1A   = 19'h02000,
    S_W2I   = 19'h04000,
    S_W2P   = 19'h08000,
    S_W2E   = 19'h10000,
    S_W2A   = 19'h20000,
    S_PEND  = 19'h40000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch_item = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          apfb_pkg::OP_CLEAR: begin
            cmd.clr_graph = 1'b1;
            cmd.emit_ok = 1'b1;
            state_next = S_IDLE;
          end
          apfb_pkg::OP_APPEND: begin
            cmd.deg_rd_from = 1'b1;
            state_next = S_APP;
          end
          apfb_pkg::OP_ZERO: begin
            state_next = S_SWEEP;
          end
          default: begin
            if (sts.run_bad) begin
              cmd.emit_run = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.phase_init = 1'b1;
              state_next = S_SINIT;
            end
          end
        endcase
      end
      S_APP: begin
        cmd.append_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.emit_ok = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        if (sts.q_empty) begin
          state_next = S_WCHK;
        end else begin
          cmd.q_rd = 1'b1;
          state_next = S_NODE;
        end
      end
      S_NODE: begin
        cmd.cur_load = 1'b1;
        state_next = S_DEG;
      end
      S_DEG: begin
        cmd.deg_cap = 1'b1;
        state_next = S_EDGE;
      end
      S_EDGE: begin
        if (sts.k_done) begin
          state_next = S_POP;
        end else begin
          cmd.edge_rd = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.edge_eval = 1'b1;
        state_next = S_EDGE;
      end
      S_WCHK: begin
        if (sts.sink_reached) begin
          cmd.walk_init = 1'b1;
          cmd.neck_init = 1'b1;
          state_next = S_W1P;
        end else begin
          state_next = S_PEND;
        end
      end
      S_W1P: begin
        if (sts.walk_more) begin
          cmd.pred_rd = 1'b1;
          state_next = S_W1E;
        end else begin
          state_next = S_W2I;
        end
      end
      S_W1E: begin
        cmd.walk_edge_rd = 1'b1;
        state_next = S_W1A;
      end
      S_W1A: begin
        cmd.neck_upd = 1'b1;
        state_next = S_W1P;
      end
      S_W2I: begin
        cmd.walk_init = 1'b1;
        state_next = S_W2P;
      end
      S_W2P: begin
        if (sts.walk_more) begin
          cmd.pred_rd = 1'b1;
          state_next = S_W2E;
        end else begin
          cmd.total_add = 1'b1;
          state_next = S_SINIT;
        end
      end
      S_W2E: begin
        cmd.walk_edge_rd = 1'b1;
        state_next = S_W2A;
      end
      S_W2A: begin
        cmd.flow_upd = 1'b1;
        state_next = S_W2P;
      end
      S_PEND: begin
        if (sts.first_pass && sts.two_pass) begin
          cmd.pass_next = 1'b1;
          state_next = S_SINIT;
        end else begin
          cmd.emit_run = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/apfb_dpath.sv
// graph tables, search queue, path registers and result word
module apfb_dpath #(
  parameter int MAX_NODES  = apfb_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE = apfb_pkg::DEF_MAX_DEGREE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  apfb_pkg::item_t                     item,
  input  logic                                cfg_we,
  input  logic [apfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  apfb_pkg::cmd_t                      cmd,
  output apfb_pkg::sts_t                      sts,
  output logic                                done,
  output apfb_pkg::result_t                   result
);

  localparam int NIW   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int KW    = $clog2(MAX_DEGREE + 1);
  localparam int SLOTS = MAX_NODES * MAX_DEGREE;
  localparam int SW    = $clog2(SLOTS);
  localparam int TW    = $clog2(MAX_NODES + 1);
  localparam int NW    = apfb_pkg::NODE_W;
  localparam int CW    = apfb_pkg::CAP_W;
  localparam int FW    = apfb_pkg::FLOW_W;

  typedef struct packed {
    logic [SW-1:0]  slot;
    logic [NIW-1:0] node;
  } pred_t;

  // configuration registers
  logic [NW-1:0] src_node, snk_node, avd_node;
  logic [1:0]    mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_node <= '0;
      snk_node <= NW'(1);
      avd_node <= '0;
      mode     <= apfb_pkg::MODE_PLAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        apfb_pkg::CFG_SOURCE: src_node <= cfg_data[NW-1:0];
        apfb_pkg::CFG_SINK:   snk_node <= cfg_data[NW-1:0];
        apfb_pkg::CFG_AVOID:  avd_node <= cfg_data[NW-1:0];
        apfb_pkg::CFG_MODE:   mode     <= cfg_data[1:0];
        default:              mode     <= mode;
      endcase
    end
  end

  // latched item
  apfb_pkg::item_t itm;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      itm <= item;
    end
  end

  // memories and their read registers
  logic [KW-1:0]  deg_mem  [MAX_NODES];
  logic [NW-1:0]  dest_mem [SLOTS];
  logic [CW-1:0]  cap_mem  [SLOTS];
  logic [CW-1:0]  flow_mem [SLOTS];
  pred_t          pred_mem [MAX_NODES];
  logic [NIW-1:0] q_mem    [MAX_NODES];

  logic [MAX_NODES-1:0] deg_valid, visited, pv;
  logic [KW-1:0]  deg_q, deg_cur, k;
  logic           deg_vq;
  logic [NW-1:0]  dest_q;
  logic [CW-1:0]  cap_q, flow_q, neck;
  pred_t          pred_q;
  logic [NIW-1:0] q_q, cur, walk_node;
  logic [TW-1:0]  head, tail, steps;
  logic [SW-1:0]  slot_q, wslot, sweep_idx;
  logic [FW-1:0]  total;
  logic           excl, first_pass;

  logic [KW-1:0]  deg_out;
  logic [NIW-1:0] deg_ra, from_i, snk_i, src_i, d_i;
  logic [SW-1:0]  srch_slot, app_slot, edge_ra, flow_wa;
  logic [CW-1:0]  flow_wd, spare;
  logic           flow_we, app_drop, d_take;
  logic [FW:0]    sum;

  assign deg_out   = deg_vq ? deg_q : '0;
  assign from_i    = NIW'(itm.from_node);
  assign snk_i     = NIW'(snk_node);
  assign src_i     = NIW'(src_node);
  assign d_i       = NIW'(dest_q);
  assign deg_ra    = cmd.deg_rd_from ? from_i : q_q;
  assign srch_slot = SW'(cur) * SW'(MAX_DEGREE) + SW'(k);
  assign app_slot  = SW'(from_i) * SW'(MAX_DEGREE) + SW'(deg_out);
  assign edge_ra   = cmd.walk_edge_rd ? pred_q.slot : srch_slot;
  assign app_drop  = (32'(itm.from_node) >= MAX_NODES) || (32'(deg_out) >= MAX_DEGREE);
  assign spare     = cap_q - flow_q;
  assign sum       = {1'b0, total} + (FW + 1)'(neck);

  // edge admission during the search
  assign d_take = (32'(dest_q) < MAX_NODES) && !visited[d_i] && (dest_q != src_node)
                  && (cap_q > flow_q) && !(excl && (dest_q == avd_node));

  // flow write port selection
  always_comb begin
    flow_we = 1'b0;
    flow_wa = sweep_idx;
    flow_wd = '0;
    if (cmd.append_wr && !app_drop) begin
      flow_we = 1'b1;
      flow_wa = app_slot;
    end else if (cmd.sweep_wr) begin
      flow_we = 1'b1;
    end else if (cmd.flow_upd) begin
      flow_we = 1'b1;
      flow_wa = wslot;
      flow_wd = flow_q + neck;
    end
  end

  // degree table
  always_ff @(posedge clk) begin
    deg_q <= deg_mem[deg_ra];
    if (cmd.append_wr && !app_drop) begin
      deg_mem[from_i] <= deg_out + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_valid <= '0;
      deg_vq    <= 1'b0;
    end else begin
      deg_vq <= deg_valid[deg_ra];
      if (cmd.clr_graph) begin
        deg_valid <= '0;
      end else if (cmd.append_wr && !app_drop) begin
        deg_valid[from_i] <= 1'b1;
      end
    end
  end

  // edge tables
  always_ff @(posedge clk) begin
    dest_q <= dest_mem[edge_ra];
    cap_q  <= cap_mem[edge_ra];
    flow_q <= flow_mem[edge_ra];
    if (cmd.append_wr && !app_drop) begin
      dest_mem[app_slot] <= itm.to_node;
      cap_mem[app_slot]  <= itm.edge_capacity;
    end
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
  end

  // predecessor table and search queue
  always_ff @(posedge clk) begin
    if (cmd.pred_rd) begin
      pred_q <= pred_mem[walk_node];
    end
    q_q <= q_mem[NIW'(head)];
    if (cmd.edge_eval && d_take) begin
      pred_mem[d_i] <= '{slot: slot_q, node: cur};
    end
    if (cmd.srch_init) begin
      q_mem[0] <= src_i;
    end else if (cmd.edge_eval && d_take && (tail < TW'(MAX_NODES))) begin
      q_mem[NIW'(tail)] <= d_i;
    end
  end

  // search marks
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      pv      <= '0;
    end else if (cmd.srch_init) begin
      visited <= MAX_NODES'(1) << src_i;
      pv      <= '0;
    end else if (cmd.edge_eval && d_take) begin
      visited[d_i] <= 1'b1;
      pv[d_i]      <= 1'b1;
    end
  end

  // search counters and current node
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      head <= '0;
      tail <= TW'(1);
    end else begin
      if (cmd.q_rd) begin
        head <= head + TW'(1);
      end
      if (cmd.edge_eval && d_take && (tail < TW'(MAX_NODES))) begin
        tail <= tail + TW'(1);
      end
    end
    if (cmd.cur_load) begin
      cur <= q_q;
      k   <= '0;
    end
    if (cmd.deg_cap) begin
      deg_cur <= deg_out;
    end
    if (cmd.edge_rd) begin
      slot_q <= srch_slot;
      k      <= k + KW'(1);
    end
  end

  // path walks and flow totals
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_node <= snk_i;
      steps     <= '0;
    end else if (cmd.walk_edge_rd) begin
      walk_node <= pred_q.node;
      wslot     <= pred_q.slot;
      steps     <= steps + TW'(1);
    end
    if (cmd.neck_init) begin
      neck <= '1;
    end else if (cmd.neck_upd && (spare < neck)) begin
      neck <= spare;
    end
    if (cmd.phase_init || cmd.pass_next) begin
      total <= '0;
    end else if (cmd.total_add) begin
      total <= sum[FW] ? '1 : sum[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      excl       <= 1'b0;
      first_pass <= 1'b0;
    end else if (cmd.phase_init) begin
      excl       <= (mode == apfb_pkg::MODE_AVOID) || (mode == apfb_pkg::MODE_BETW);
      first_pass <= 1'b1;
    end else if (cmd.pass_next) begin
      excl       <= 1'b0;
      first_pass <= 1'b0;
    end
  end

  // zero-flow sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_idx <= (sweep_idx == SW'(SLOTS - 1)) ? '0 : sweep_idx + SW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_ok || cmd.emit_run || cmd.append_wr;
    end
    if (cmd.emit_run) begin
      result.status     <= apfb_pkg::ST_RUN;
      result.total_flow <= sts.run_bad ? '0 : total;
    end else if (cmd.append_wr) begin
      result.status     <= app_drop ? apfb_pkg::ST_DROP : apfb_pkg::ST_OK;
      result.total_flow <= '0;
    end else if (cmd.emit_ok) begin
      result.status     <= apfb_pkg::ST_OK;
      result.total_flow <= '0;
    end
  end

  // status to the controller
  assign sts.op           = itm.opcode;
  assign sts.run_bad      = (32'(src_node) >= MAX_NODES) || (32'(snk_node) >= MAX_NODES);
  assign sts.sweep_last   = (sweep_idx == SW'(SLOTS - 1));
  assign sts.q_empty      = (head == tail);
  assign sts.k_done       = (k >= deg_cur);
  assign sts.sink_reached = pv[snk_i];
  assign sts.walk_more    = pv[walk_node] && (steps < TW'(MAX_NODES));
  assign sts.two_pass     = (mode == apfb_pkg::MODE_BETW);
  assign sts.first_pass   = first_pass;

endmodule

// File: hdl/augmenting_path_flow_betweenness.sv
// Clear, append and zero-all-flows each finish with one result word; the zero pass sweeps every
// edge slot. A run does one search per augmenting path and a final failing search per phase,
// then walks each path twice through the edge and predecessor tables: once for the
// bottleneck and once to add it to each edge's flow. One item at a time, busy meanwhile.
// Reset (synchronous) clears the controller, degrees, marks and registers; no clearing pass.
// Results come on done for one cycle and cannot be stalled.
module augmenting_path_flow_betweenness #(
  parameter int MAX_NODES  = apfb_pkg::DEF_MAX_NODES,
  parameter int MAX_DEGREE = apfb_pkg::DEF_MAX_DEGREE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  apfb_pkg::item_t                 item,
  output logic                            busy,
  output logic                            done,
  output apfb_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [apfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  apfb_pkg::cmd_t cmd;
  apfb_pkg::sts_t sts;

  // sequencer
  apfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // tables and arithmetic
  apfb_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

`ifndef ASSERT_OFF
  // a word leaves only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  // an accepted item keeps the block busy in the next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // only a run reports flow
  a_flow_run: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.total_flow == '0) || (result.status == apfb_pkg::ST_RUN))
    else $error("flow reported for a non-run word");

  // status code is never the unused value
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == apfb_pkg::ST_OK) || (result.status == apfb_pkg::ST_DROP)
             || (result.status == apfb_pkg::ST_RUN))
    else $error("bad status code");
`endif

endmodule

// File: dv/tb.sv
// testbench for the augmenting path flow block: scoreboard, stimulus and checks
`timescale 1ns / 100ps

import apfb_pkg::*;

// scoreboard: predicts each result word from its own copy of the graph
class flow_scoreboard;
  localparam int NODES = DEF_MAX_NODES;
  localparam int DEG   = DEF_MAX_DEGREE;

  logic [NODE_W-1:0] src_reg, snk_reg, avoid_reg;
  logic [1:0]        mode_reg;

  logic [NODE_W-1:0] dest_tab [NODES*DEG];
  logic [CAP_W-1:0]  cap_tab  [NODES*DEG];
  logic [CAP_W-1:0]  flow_tab [NODES*DEG];
  int                degree   [NODES];
  int                pred     [NODES];
  bit                pred_ok  [NODES];

  result_t expected_words[$];
  int      mismatches;

  function new();
    src_reg = 0; snk_reg = 1; avoid_reg = 0; mode_reg = MODE_PLAIN;
    mismatches = 0;
    foreach (degree[i]) degree[i] = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SOURCE: src_reg = val;
      CFG_SINK:   snk_reg = val;
      CFG_AVOID:  avoid_reg = val;
      default:    mode_reg = val[1:0];
    endcase
  endfunction

  // breadth-first search over unsaturated edges
  function void bfs(int s, bit excl);
    bit seen [NODES];
    int q[$];
    int cur, slot, d;
    foreach (seen[i]) begin
      seen[i] = 0;
      pred_ok[i] = 0;
    end
    seen[s] = 1;
    q.push_back(s);
    while (q.size() > 0) begin
      cur = q.pop_front();
      for (int k = 0; k < degree[cur] && k < DEG; k++) begin
        slot = cur * DEG + k;
        d = dest_tab[slot];
        if (seen[d] || d == s) continue;
        if (cap_tab[slot] <= flow_tab[slot]) continue;
        if (excl && d == avoid_reg) continue;
        pred[d] = slot;
        pred_ok[d] = 1;
        seen[d] = 1;
        q.push_back(d);
      end
    end
  endfunction

  function logic [FLOW_W-1:0] augment(bit excl);
    logic [FLOW_W-1:0] total;
    logic [CAP_W-1:0]  neck, spare;
    int node, slot;
    total = 0;
    forever begin
      bfs(src_reg, excl);
      if (!pred_ok[snk_reg]) return total;
      neck = '1;
      node = snk_reg;
      for (int st = 0; pred_ok[node] && st < NODES; st++) begin
        slot = pred[node];
        spare = cap_tab[slot] - flow_tab[slot];
        if (spare < neck) neck = spare;
        node = slot / DEG;
      end
      node = snk_reg;
      for (int st = 0; pred_ok[node] && st < NODES; st++) begin
        slot = pred[node];
        flow_tab[slot] = flow_tab[slot] + neck;
        node = slot / DEG;
      end
      total = (total > 32'hFFFF_FFFF - neck) ? 32'hFFFF_FFFF : total + neck;
    end
  endfunction

  // note an accepted input word
  function void note_item(item_t it);
    result_t r;
    int slot;
    r.status = ST_OK;
    r.total_flow = 0;
    case (it.opcode)
      OP_CLEAR: foreach (degree[i]) degree[i] = 0;
      OP_APPEND: begin
        if (degree[it.from_node] >= DEG) begin
          r.status = ST_DROP;
        end else begin
          slot = it.from_node * DEG + degree[it.from_node];
          dest_tab[slot] = it.to_node;
          cap_tab[slot] = it.edge_capacity;
          flow_tab[slot] = 0;
          degree[it.from_node]++;
        end
      end
      OP_ZERO: begin
        for (int n = 0; n < NODES; n++)
          for (int k = 0; k < degree[n]; k++) flow_tab[n * DEG + k] = 0;
      end
      default: begin
        r.status = ST_RUN;
        if (mode_reg == MODE_AVOID) begin
          r.total_flow = augment(1);
        end else if (mode_reg == MODE_BETW) begin
          void'(augment(1));
          r.total_flow = augment(0);
        end else begin
          r.total_flow = augment(0);
        end
      end
    endcase
    expected_words.push_back(r);
  endfunction

  // compare a result word with the oldest expectation
  function void check_word(result_t got);
    result_t exp_w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got.status !== exp_w.status || got.total_flow !== exp_w.total_flow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected status %0d flow %0d, got status %0d flow %0d",
                 exp_w.status, exp_w.total_flow, got.status, got.total_flow);
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  item_t item = '0;
  logic busy, done;
  result_t result;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flow_scoreboard flow_sb;
  int calm_lo, calm_hi, sent;

  augmenting_path_flow_betweenness dut (
    .clk, .rst, .start, .item, .busy, .done, .result, .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) flow_sb.check_word(result);
  end

  // run limit
  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  // send one word, idling at random outside the calm stretch
  task automatic send_word(item_t it);
    @(negedge clk);
    while (!(sent >= calm_lo && sent < calm_hi) && $urandom_range(99) < 14)
      @(negedge clk);
    item <= it;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    flow_sb.note_item(it);
    sent++;
    @(negedge clk);
    start <= 0;
  endtask

  task automatic send_op(logic [1:0] op, int f, int t, logic [CAP_W-1:0] c);
    item_t it;
    it.opcode = op;
    it.from_node = NODE_W'(f);
    it.to_node = NODE_W'(t);
    it.edge_capacity = c;
    send_word(it);
  endtask

  // wait for all results, then settle before a register write
  task automatic drain();
    while (flow_sb.expected_words.size() > 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    flow_sb.write_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
  endtask

  task automatic set_regs(int s, int k, int a, int m);
    drain();
    write_reg(CFG_SOURCE, s);
    write_reg(CFG_SINK, k);
    write_reg(CFG_AVOID, a);
    write_reg(CFG_MODE, m);
  endtask

  // random word: mostly appends within a few nodes around source and sink
  task automatic random_word();
    int r;
    logic [CAP_W-1:0] c;
    r = $urandom_range(99);
    c = ($urandom_range(9) == 0) ? CAP_W'($urandom) : CAP_W'($urandom_range(40));
    if (r < 60)
      send_op(OP_APPEND, $urandom_range(7), $urandom_range(7), c);
    else if (r < 65)
      send_op(OP_APPEND, $urandom_range(63), $urandom_range(63), CAP_W'($urandom));
    else if (r < 85)
      send_op(OP_RUN, $urandom_range(63), $urandom_range(63), CAP_W'($urandom));
    else if (r < 93)
      send_op(OP_ZERO, $urandom_range(63), $urandom_range(63), CAP_W'($urandom));
    else
      send_op(OP_CLEAR, $urandom_range(63), $urandom_range(63), CAP_W'($urandom));
  endtask

  initial begin
    flow_sb = new();
    sent = 0;
    calm_lo = 250;
    calm_hi = 330;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, full list, sink equals source, avoided sink
    send_op(OP_RUN, 63, 63, '1);
    send_op(OP_APPEND, 0, 2, '1);
    send_op(OP_APPEND, 2, 1, '1);
    send_op(OP_APPEND, 0, 1, 31'h7FFF_FFFE);
    send_op(OP_APPEND, 0, 3, 0);
    send_op(OP_RUN, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    send_op(OP_ZERO, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_op(OP_APPEND, 63, 63 - i, 31'd5);
    send_op(OP_APPEND, 63, 0, 31'd5);
    set_regs(63, 63, 2, MODE_PLAIN);
    send_op(OP_RUN, 0, 0, 0);
    set_regs(0, 1, 2, MODE_AVOID);
    send_op(OP_ZERO, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    set_regs(0, 1, 1, MODE_AVOID);
    send_op(OP_ZERO, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    set_regs(0, 1, 2, MODE_BETW);
    send_op(OP_ZERO, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    set_regs(0, 1, 0, 3);
    send_op(OP_ZERO, 0, 0, 0);
    send_op(OP_RUN, 0, 0, 0);
    send_op(OP_CLEAR, 0, 0, 0);

    // random phases across register settings
    for (int p = 0; p < 8; p++) begin
      set_regs($urandom_range(3), (p == 7) ? 0 : $urandom_range(1, 7), $urandom_range(7),
               $urandom_range(3));
      for (int i = 0; i < 66; i++) random_word();
    end

    drain();
    if (flow_sb.mismatches == 0 && flow_sb.expected_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
